// ===== rtl/core/cmpc_pkg.sv =====
`timescale 1ns / 1ps

package cmpc_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;
  localparam int NCELLS    = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(NCELLS);
  localparam int CTR_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CNT_W     = $clog2(NCELLS + 1);
  localparam int WORD_W    = 2 * ELEM_BITS;
  localparam int OUT_W     = 40;
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int TERM_W    = PROD_W + 1;
  localparam int ACC_W     = TERM_W + $clog2(2 * MAX_DIM);
  localparam int SAT_W     = (ACC_W > OUT_W) ? ACC_W : OUT_W;

  localparam logic signed [SAT_W-1:0] OUT_MAX =
    {{(SAT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] OUT_MIN =
    {{(SAT_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

  // configuration port
  localparam int SIZE_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [SIZE_W-1:0]    SIZE_RST = SIZE_W'(8);
  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] a_re;
    logic signed [ELEM_BITS-1:0] a_im;
    logic signed [ELEM_BITS-1:0] b_re;
    logic signed [ELEM_BITS-1:0] b_im;
    logic                        load_last;
  } cmpc_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] c_re;
    logic signed [OUT_W-1:0] c_im;
    logic [ADDR_W-1:0]       out_index;
    logic                    out_last;
  } cmpc_out_t;

  // control that travels with each multiply-accumulate step
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              neg;
    logic              last_elem;
    logic [ADDR_W-1:0] idx;
  } cmpc_tag_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > OUT_MAX) begin
      w = OUT_MAX;
    end else if (w < OUT_MIN) begin
      w = OUT_MIN;
    end
    return w[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/complex_matrix_product_commutator_unit.sv =====
`timescale 1ns / 1ps
// Loading accepts one element pair per cycle; in_ready is low from the last load until the
// final result is transferred. One complex multiply-accumulate unit fed by two one-port
// element memories does n*n*n steps (2*n*n*n for the commutator). Reset clears control,
// config (mode 0, size 8) and the load count; element memories are not cleared.

module complex_matrix_product_commutator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cmpc_pkg::cmpc_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cmpc_pkg::cmpc_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [cmpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cmpc_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DRAIN} state_t;

  state_t             state_r, state_nxt;
  logic               mode_r;
  logic [SIZE_W-1:0]  size_r;
  logic [DIM_W-1:0]   n_cfg, n_r, n_nxt;
  logic [CTR_W-1:0]   nm1;
  logic               run_mode_r, run_mode_nxt;
  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [CTR_W-1:0]   r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic               pass_r, pass_nxt;
  logic [ADDR_W-1:0]  rowb_r, rowb_nxt, kbase_r, kbase_nxt;
  logic [ADDR_W-1:0]  addr1, addr2, a_raddr, b_raddr;
  logic               in_acc, out_acc, adv, mem_we;
  cmpc_tag_t          tag0, t1_r;

  logic [WORD_W-1:0]  a_mem [NCELLS];
  logic [WORD_W-1:0]  b_mem [NCELLS];
  logic [WORD_W-1:0]  a_q_r, b_q_r;

  logic               res_valid;
  cmpc_out_t          res;
  logic               out_valid_r;
  cmpc_out_t          out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      size_r <= SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE: mode_r <= cfg_wdata[0];
        REG_SIZE: size_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_r == '0) begin
      n_cfg = DIM_W'(1);
    end else if (size_r > SIZE_W'(MAX_DIM)) begin
      n_cfg = DIM_W'(MAX_DIM);
    end else begin
      n_cfg = DIM_W'(size_r);
    end
  end

  assign nm1      = CTR_W'(n_r - DIM_W'(1));
  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign adv      = !out_valid_r || out_ready;
  assign mem_we   = in_acc && (load_cnt_r < CNT_W'(NCELLS));

  // step order: k inner, then pass, then column, then row
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    n_nxt        = n_r;
    run_mode_nxt = run_mode_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    pass_nxt     = pass_r;
    rowb_nxt     = rowb_r;
    kbase_nxt    = kbase_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (mem_we) begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end
          if (in_data.load_last) begin
            state_nxt    = ST_RUN;
            load_cnt_nxt = '0;
            n_nxt        = n_cfg;
            run_mode_nxt = mode_r;
            r_nxt        = '0;
            c_nxt        = '0;
            k_nxt        = '0;
            pass_nxt     = 1'b0;
            rowb_nxt     = '0;
            kbase_nxt    = '0;
          end
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (k_r == nm1) begin
            k_nxt     = '0;
            kbase_nxt = '0;
            if (pass_r == run_mode_r) begin
              pass_nxt = 1'b0;
              if (c_r == nm1) begin
                c_nxt    = '0;
                r_nxt    = r_r + CTR_W'(1);
                rowb_nxt = rowb_r + ADDR_W'(n_r);
                if (r_r == nm1) begin
                  state_nxt = ST_DRAIN;
                  r_nxt     = '0;
                  rowb_nxt  = '0;
                end
              end else begin
                c_nxt = c_r + CTR_W'(1);
              end
            end else begin
              pass_nxt = 1'b1;
            end
          end else begin
            k_nxt     = k_r + CTR_W'(1);
            kbase_nxt = kbase_r + ADDR_W'(n_r);
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_data_r.out_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      n_r        <= '0;
      run_mode_r <= 1'b0;
      r_r        <= '0;
      c_r        <= '0;
      k_r        <= '0;
      pass_r     <= 1'b0;
      rowb_r     <= '0;
      kbase_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      n_r        <= n_nxt;
      run_mode_r <= run_mode_nxt;
      r_r        <= r_nxt;
      c_r        <= c_nxt;
      k_r        <= k_nxt;
      pass_r     <= pass_nxt;
      rowb_r     <= rowb_nxt;
      kbase_r    <= kbase_nxt;
    end
  end

  // addresses: row r of the left factor, column c of the right factor
  assign addr1   = rowb_r + ADDR_W'(k_r);
  assign addr2   = kbase_r + ADDR_W'(c_r);
  assign a_raddr = pass_r ? addr2 : addr1;
  assign b_raddr = pass_r ? addr1 : addr2;

  always_comb begin
    tag0.valid     = (state_r == ST_RUN);
    tag0.first     = (k_r == '0) && !pass_r;
    tag0.last      = (k_r == nm1) && (pass_r == run_mode_r);
    tag0.neg       = pass_r;
    tag0.last_elem = (r_r == nm1) && (c_r == nm1);
    tag0.idx       = rowb_r + ADDR_W'(c_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      a_mem[load_cnt_r[ADDR_W-1:0]] <= {in_data.a_re, in_data.a_im};
      b_mem[load_cnt_r[ADDR_W-1:0]] <= {in_data.b_re, in_data.b_im};
    end
    if (adv) begin
      a_q_r <= a_mem[a_raddr];
      b_q_r <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
    end else if (adv) begin
      t1_r <= tag0;
    end
  end

  cmpc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tag_in    (t1_r),
    .a_word    (a_q_r),
    .b_word    (b_q_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register: hold while stalled, load the finished element on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_out_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("result pending while loading");

  a_pipe_empty_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> !t1_r.valid)
    else $error("step in flight while loading");

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_last) |-> (state_r == ST_DRAIN))
    else $error("final element before sequencer finished");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data_r.out_last) |=> (state_r == ST_LOAD) && (load_cnt_r == '0))
    else $error("no return to load after final transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= CNT_W'(NCELLS))
    else $error("load count past capacity");

endmodule

// ===== rtl/core/cmpc_mac.sv =====
`timescale 1ns / 1ps

module cmpc_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  cmpc_pkg::cmpc_tag_t           tag_in,
  input  logic [cmpc_pkg::WORD_W-1:0]   a_word,
  input  logic [cmpc_pkg::WORD_W-1:0]   b_word,
  output logic                          res_valid,
  output cmpc_pkg::cmpc_out_t           res
);
  import cmpc_pkg::*;

  logic signed [ELEM_BITS-1:0] xr, xi, yr, yi;
  logic signed [PROD_W-1:0]    prr_r, pii_r, pri_r, pir_r;
  logic signed [TERM_W-1:0]    re_t, im_t;
  logic signed [TERM_W-1:0]    tre_r, tim_r;
  logic signed [ACC_W-1:0]     acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  cmpc_tag_t                   t2_r, t3_r;

  // second pass of a commutator multiplies B by A
  always_comb begin
    if (tag_in.neg) begin
      xr = $signed(b_word[WORD_W-1:ELEM_BITS]);
      xi = $signed(b_word[ELEM_BITS-1:0]);
      yr = $signed(a_word[WORD_W-1:ELEM_BITS]);
      yi = $signed(a_word[ELEM_BITS-1:0]);
    end else begin
      xr = $signed(a_word[WORD_W-1:ELEM_BITS]);
      xi = $signed(a_word[ELEM_BITS-1:0]);
      yr = $signed(b_word[WORD_W-1:ELEM_BITS]);
      yi = $signed(b_word[ELEM_BITS-1:0]);
    end
  end

  always_comb begin
    re_t = TERM_W'(prr_r) - TERM_W'(pii_r);
    im_t = TERM_W'(pri_r) + TERM_W'(pir_r);
    if (t2_r.neg) begin
      re_t = -re_t;
      im_t = -im_t;
    end
  end

  always_comb begin
    acc_re_nxt = t3_r.first ? ACC_W'(tre_r) : acc_re_r + ACC_W'(tre_r);
    acc_im_nxt = t3_r.first ? ACC_W'(tim_r) : acc_im_r + ACC_W'(tim_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_r <= '0;
      t3_r <= '0;
    end else if (adv) begin
      t2_r <= tag_in;
      t3_r <= t2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prr_r <= xr * yr;
      pii_r <= xi * yi;
      pri_r <= xr * yi;
      pir_r <= xi * yr;
      tre_r <= re_t;
      tim_r <= im_t;
      if (t3_r.valid) begin
        acc_re_r <= acc_re_nxt;
        acc_im_r <= acc_im_nxt;
      end
    end
  end

  assign res_valid     = t3_r.valid && t3_r.last;
  assign res.c_re      = sat_out(acc_re_nxt);
  assign res.c_im      = sat_out(acc_im_nxt);
  assign res.out_index = t3_r.idx;
  assign res.out_last  = t3_r.last_elem;

endmodule
